>>> hw/rtl/srr_pkg.sv
// Shared types, constants and helpers for the scanning sonar ranger.
// Used by srr_cfg, srr_seq and the top level scanning_sonar_ranger_core.
// No dependencies.
`timescale 1ns / 1ps

package srr_pkg;

  // Sizes
  localparam int ANGLE_BITS = 10;
  localparam int COUNT_BITS = 17;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int DIST_W     = 16;
  localparam int SCALE_W    = 12;
  localparam int STEP_W     = 10;
  localparam int TMO_W      = 16;
  localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int PROD_W     = COUNT_BITS + SCALE_W;
  localparam int DIST_SHIFT = 10;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TMO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0]   RST_TRIG_LOW  = 17'd2000;
  localparam logic [CFG_W-1:0]   RST_TRIG_HIGH = 17'd10000;
  localparam logic [TMO_W-1:0]   RST_ECHO_TMO  = 16'd20000;
  localparam logic [CFG_W-1:0]   RST_GAP       = 17'd100000;
  localparam logic [STEP_W-1:0]  RST_STEP      = 10'd8;
  localparam logic [SCALE_W-1:0] RST_SCALE     = 12'd1114;

  // Report status codes
  localparam logic [1:0] STATUS_GOOD      = 2'd0;
  localparam logic [1:0] STATUS_NO_ECHO   = 2'd1;
  localparam logic [1:0] STATUS_ECHO_LONG = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]   trig_low;
    logic [CFG_W-1:0]   trig_high;
    logic [TMO_W-1:0]   echo_tmo;
    logic [CFG_W-1:0]   gap;
    logic [STEP_W-1:0]  angle_step;
    logic [SCALE_W-1:0] scale;
  } srr_cfg_t;

  typedef struct packed {
    logic                  trigger;
    logic                  led;
    logic                  valid;
    logic [1:0]            status;
    logic [ANGLE_BITS-1:0] angle;
    logic [DIST_W-1:0]     distance;
    logic                  calibrated;
  } srr_result_t;

  // count >= limit, with the limit clamped to the counter's maximum
  function automatic logic cnt_ge(logic [COUNT_BITS-1:0] cnt, logic [CFG_W-1:0] lim);
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] l;
    c = CMP_W'(cnt);
    l = CMP_W'(lim);
    if (l > CMP_W'(COUNT_MAX)) begin
      l = CMP_W'(COUNT_MAX);
    end
    return c >= l;
  endfunction

  // count > limit, with the limit clamped to the counter's maximum
  function automatic logic cnt_gt(logic [COUNT_BITS-1:0] cnt, logic [CFG_W-1:0] lim);
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] l;
    c = CMP_W'(cnt);
    l = CMP_W'(lim);
    if (l > CMP_W'(COUNT_MAX)) begin
      l = CMP_W'(COUNT_MAX);
    end
    return c > l;
  endfunction

endpackage

>>> hw/rtl/srr_cfg.sv
// Configuration register file of the scanning sonar ranger.
// Depends on srr_pkg for register indexes, reset values and srr_cfg_t.
`timescale 1ns / 1ps

module srr_cfg import srr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output srr_cfg_t             cfg
);

  // Write by index; data is cut to each register's width, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trig_low   <= RST_TRIG_LOW;
      cfg.trig_high  <= RST_TRIG_HIGH;
      cfg.echo_tmo   <= RST_ECHO_TMO;
      cfg.gap        <= RST_GAP;
      cfg.angle_step <= RST_STEP;
      cfg.scale      <= RST_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIG_LOW:  cfg.trig_low   <= cfg_data;
        REG_TRIG_HIGH: cfg.trig_high  <= cfg_data;
        REG_ECHO_TMO:  cfg.echo_tmo   <= cfg_data[TMO_W-1:0];
        REG_GAP:       cfg.gap        <= cfg_data;
        REG_STEP:      cfg.angle_step <= cfg_data[STEP_W-1:0];
        REG_SCALE:     cfg.scale      <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/srr_seq.sv
// Ranging sequencer: scan angle tracking, trigger/echo phase machine and
// distance scaling for one tick. Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_seq import srr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        echo,
  input  logic        pulse,
  input  logic        center,
  input  srr_cfg_t    cfg,
  output srr_result_t res
);

  typedef enum logic [2:0] {
    PH_WAIT_CENTER,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE,
    PH_GAP
  } phase_t;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] phase_count, phase_count_next;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [ANGLE_BITS-1:0] angle, angle_next;
  logic                  led, led_next;
  logic                  seen_center, seen_center_next;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_sh;
  logic [DIST_W-1:0]     dist_sat;

  // Distance = (duration * scale) >> 10, saturated
  assign prod     = PROD_W'(phase_count) * PROD_W'(cfg.scale);
  assign prod_sh  = prod >> DIST_SHIFT;
  assign dist_sat = (prod_sh > PROD_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : prod_sh[DIST_W-1:0];

  // Saturating tick counter
  assign cnt_inc = (phase_count == COUNT_MAX) ? phase_count : phase_count + 1'b1;

  // Next state and result for this tick
  always_comb begin
    angle_next       = angle;
    seen_center_next = seen_center;
    if (center) begin
      angle_next       = '0;
      seen_center_next = 1'b1;
    end else if (pulse) begin
      angle_next = angle + ANGLE_BITS'(cfg.angle_step);
    end

    phase_next       = phase;
    phase_count_next = phase_count;
    led_next         = led;
    res              = '0;

    unique case (phase)
      PH_WAIT_CENTER: begin
        if (seen_center_next) begin
          phase_next       = PH_TRIG_LOW;
          phase_count_next = '0;
        end
      end
      PH_TRIG_LOW: begin
        phase_count_next = cnt_inc;
        if (cnt_ge(cnt_inc, cfg.trig_low)) begin
          phase_next       = PH_TRIG_HIGH;
          phase_count_next = '0;
        end
      end
      PH_TRIG_HIGH: begin
        res.trigger      = 1'b1;
        phase_count_next = cnt_inc;
        if (cnt_ge(cnt_inc, cfg.trig_high)) begin
          phase_next       = PH_WAIT_RISE;
          phase_count_next = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_next       = PH_MEASURE;
          phase_count_next = COUNT_BITS'(1);
        end else begin
          phase_count_next = cnt_inc;
          if (cnt_gt(cnt_inc, CFG_W'(cfg.echo_tmo))) begin
            res.valid        = 1'b1;
            res.status       = STATUS_NO_ECHO;
            res.angle        = angle_next;
            phase_next       = PH_TRIG_LOW;
            phase_count_next = '0;
          end
        end
      end
      PH_MEASURE: begin
        if (!echo) begin
          res.valid        = 1'b1;
          res.status       = STATUS_GOOD;
          res.angle        = angle_next;
          res.distance     = dist_sat;
          led_next         = ~led;
          phase_next       = (cfg.gap == '0) ? PH_TRIG_LOW : PH_GAP;
          phase_count_next = '0;
        end else begin
          phase_count_next = cnt_inc;
          if (cnt_gt(cnt_inc, CFG_W'(cfg.echo_tmo))) begin
            res.valid        = 1'b1;
            res.status       = STATUS_ECHO_LONG;
            res.angle        = angle_next;
            phase_next       = PH_TRIG_LOW;
            phase_count_next = '0;
          end
        end
      end
      PH_GAP: begin
        phase_count_next = cnt_inc;
        if (cnt_ge(cnt_inc, cfg.gap)) begin
          phase_next       = PH_TRIG_LOW;
          phase_count_next = '0;
        end
      end
      default: begin
        phase_next       = PH_WAIT_CENTER;
        phase_count_next = '0;
      end
    endcase

    res.led        = led_next;
    res.calibrated = seen_center_next;
  end

  // State advances once per word moved into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT_CENTER;
      phase_count <= '0;
      angle       <= '0;
      led         <= 1'b0;
      seen_center <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      phase_count <= phase_count_next;
      angle       <= angle_next;
      led         <= led_next;
      seen_center <= seen_center_next;
    end
  end

  // Checks
  a_led_only_on_good: assert property (@(posedge clk) disable iff (rst)
    (advance && (led_next != led)) |-> (res.valid && (res.status == STATUS_GOOD)))
    else $error("LED toggled without a good report");

  a_idle_until_center: assert property (@(posedge clk) disable iff (rst)
    !seen_center |-> (phase == PH_WAIT_CENTER))
    else $error("ranging started before calibration");

  a_measure_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MEASURE) |-> (phase_count != '0))
    else $error("echo duration lost its rise tick");

  a_report_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ((phase == PH_WAIT_RISE) || (phase == PH_MEASURE)))
    else $error("report outside the echo phases");

endmodule

>>> hw/rtl/scanning_sonar_ranger_core.sv
// Top level of the scanning sonar ranger: input register, sequencer, output register.
// Depends on srr_pkg, srr_cfg and srr_seq.
`timescale 1ns / 1ps

// Each input word is one microsecond tick of echo level, motor pulse and center
// switch; each accepted word yields exactly one output word, passing through the
// input register and then the output register, and a new word is taken every
// clock as long as the output side does not stall. The sequencer between the
// two registers does all the per-tick work in one pass, the longest path being
// the 17x12 multiply and saturation of the distance. Configuration writes take
// effect on the next word the sequencer processes.
module scanning_sonar_ranger_core import srr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  echo_level,
  input  logic                  motor_pulse,
  input  logic                  center_hit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  trigger_level,
  output logic                  led_level,
  output logic                  result_valid,
  output logic [1:0]            result_status,
  output logic [ANGLE_BITS-1:0] scan_angle,
  output logic [DIST_W-1:0]     distance,
  output logic                  calibrated
);

  srr_cfg_t    cfg;
  srr_result_t res;
  logic        s1_valid;
  logic        s1_echo, s1_pulse, s1_center;
  logic        out_ready;
  logic        advance;

  // Handshake: output register drains or empty lets stage 1 move on
  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  srr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srr_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .echo    (s1_echo),
    .pulse   (s1_pulse),
    .center  (s1_center),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_echo   <= echo_level;
      s1_pulse  <= motor_pulse;
      s1_center <= center_hit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger_level <= res.trigger;
      led_level     <= res.led;
      result_valid  <= res.valid;
      result_status <= res.status;
      scan_angle    <= res.angle;
      distance      <= res.distance;
      calibrated    <= res.calibrated;
    end
  end

  // Checks
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_valid))
    else $error("input stalled with room in the pipeline");

  a_word_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_ready) |=> s1_valid)
    else $error("held input word was dropped");

  a_report_fields_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_valid) |-> ((result_status == STATUS_GOOD) && (distance == '0)))
    else $error("stray report fields without a report");

endmodule
